[src/ihp_pkg.sv]
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types and constants of the IPv4 header prepend block.
// ----------------------------------------------------------------------------
package ihp_pkg;

  localparam int HDR_BYTES   = 20;
  localparam int CNT_W       = 5;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int S_TDATA_W   = 96;
  localparam int TTL_RESET   = 64;

  localparam logic [7:0]  VER_IHL     = 8'h45;
  localparam logic [7:0]  TOS_BYTE    = 8'h00;
  localparam logic [15:0] IDENT       = 16'h0000;
  localparam logic [15:0] FLAGS_FRAG  = 16'h4000;
  localparam logic [15:0] WORD0       = {VER_IHL, TOS_BYTE};
  localparam logic [0:0]  REG_TTL     = 1'b0;

  typedef struct packed {
    logic [7:0]  pbyte;
    logic        first;
    logic        last;
    logic [15:0] plen;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic [15:0] tlen;
  } hdr_item_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] hdr_left;
  } ser_stat_t;

endpackage

[src/ihp_csum.sv]
// ----------------------------------------------------------------------------
// ihp_csum
// Four-stage pipeline computing total length and the header checksum.
// ----------------------------------------------------------------------------
module ihp_csum (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ihp_pkg::hdr_item_t in_item,
  input  logic [7:0]         ttl,
  output logic               out_valid,
  input  logic               out_ready,
  output ihp_pkg::hdr_item_t out_item,
  output logic [15:0]        out_csum
);
  import ihp_pkg::*;

  logic      v1, v2, v3, v4;
  logic      en1, en2, en3, en4;
  hdr_item_t it1, it2, it3, it4;
  logic [16:0] p0, p1, p2;
  logic [15:0] t2;
  logic [18:0] sum3;
  logic [16:0] fold4;
  logic [15:0] csum5;
  logic [16:0] fold5;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: pair sums and total length
  always_ff @(posedge clk) begin
    if (en1) begin
      it1.pbyte <= in_item.pbyte;
      it1.first <= in_item.first;
      it1.last  <= in_item.last;
      it1.plen  <= in_item.plen;
      it1.proto <= in_item.proto;
      it1.src   <= in_item.src;
      it1.dst   <= in_item.dst;
      it1.ttl   <= ttl;
      it1.tlen  <= in_item.plen + 16'(HDR_BYTES);
      p0        <= {1'b0, in_item.src[31:16]} + {1'b0, in_item.src[15:0]};
      p1        <= {1'b0, in_item.dst[31:16]} + {1'b0, in_item.dst[15:0]};
      p2        <= {1'b0, ttl, in_item.proto} + {1'b0, WORD0 + FLAGS_FRAG};
    end
  end

  // stage 2: full sum
  assign t2 = it1.tlen;
  always_ff @(posedge clk) begin
    if (en2) begin
      it2  <= it1;
      sum3 <= 19'(p0) + 19'(p1) + 19'(p2) + 19'(t2);
    end
  end

  // stage 3: first end-around fold
  always_ff @(posedge clk) begin
    if (en3) begin
      it3   <= it2;
      fold4 <= {1'b0, sum3[15:0]} + 17'(sum3[18:16]);
    end
  end

  // stage 4: second fold and complement
  assign fold5 = {1'b0, fold4[15:0]} + 17'(fold4[16]);
  always_ff @(posedge clk) begin
    if (en4) begin
      it4   <= it3;
      csum5 <= ~fold5[15:0];
    end
  end

  assign out_valid = v4;
  assign out_item  = it4;
  assign out_csum  = csum5;

endmodule

[src/ihp_serializer.sv]
// ----------------------------------------------------------------------------
// ihp_serializer
// Emits the 20 header bytes and the payload byte through an output register.
// ----------------------------------------------------------------------------
module ihp_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ihp_pkg::hdr_item_t in_item,
  input  logic [15:0]        in_csum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output ihp_pkg::ser_stat_t stat
);
  import ihp_pkg::*;

  logic [CNT_W-1:0]       cnt;
  logic                   pend;
  logic [HDR_BYTES*8-9:0] sh;
  logic [7:0]             pbyte_q;
  logic                   plast_q;
  logic                   busy;
  logic                   out_free;
  logic [HDR_BYTES*8-1:0] hdr;

  assign hdr = {VER_IHL, TOS_BYTE, in_item.tlen, IDENT, FLAGS_FRAG,
                in_item.ttl, in_item.proto, in_csum, in_item.src, in_item.dst};

  assign busy     = (cnt != '0) || pend;
  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
      pend      <= 1'b0;
    end else if (out_free) begin
      if (cnt != '0) begin
        out_valid <= 1'b1;
        cnt       <= cnt - 1'b1;
      end else if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (in_valid) begin
        out_valid <= 1'b1;
        if (in_item.first) begin
          cnt  <= CNT_W'(HDR_BYTES - 1);
          pend <= (in_item.plen != 16'h0000);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (cnt != '0) begin
        out_byte <= sh[HDR_BYTES*8-9 -: 8];
        out_last <= (cnt == CNT_W'(1)) && !pend;
        sh       <= {sh[HDR_BYTES*8-17:0], 8'h00};
      end else if (pend) begin
        out_byte <= pbyte_q;
        out_last <= plast_q;
      end else if (in_valid) begin
        if (in_item.first) begin
          out_byte <= hdr[HDR_BYTES*8-1 -: 8];
          out_last <= 1'b0;
          sh       <= hdr[HDR_BYTES*8-9:0];
          pbyte_q  <= in_item.pbyte;
          plast_q  <= in_item.last;
        end else begin
          out_byte <= in_item.pbyte;
          out_last <= in_item.last;
        end
      end
    end
  end

  assign stat.busy     = busy;
  assign stat.hdr_left = cnt;

endmodule

[src/ipv4_header_prepend.sv]
// ----------------------------------------------------------------------------
// ipv4_header_prepend
// Prepends an IPv4 header with checksum to a stream of payload bytes.
// ----------------------------------------------------------------------------
// Input stream carries one payload byte per transfer; tuser marks the first
// transfer of a packet, which also carries length, protocol and addresses.
// A first transfer yields the 20 header bytes followed by its payload byte
// (no payload byte when the length is zero); other transfers yield their
// byte. Output stream carries one byte per transfer, tlast on the final byte.
// An input transfer reaches the output through four checksum pipeline
// stages and then the output register. Non-first bytes pass at one per
// cycle while the receiver accepts them and no header is being sent; a
// first transfer holds the output for its header and any payload byte, during
// which up to four more transfers enter the pipeline till input tready drops.
// The TTL register is written over the APB port when paddr[2] is 0 (reset 64).
// Reset empties the pipeline and output register. When the receiver stalls,
// the output register holds its byte and backpressure fills the pipeline
// stage by stage before the input tready drops.
// ----------------------------------------------------------------------------
module ipv4_header_prepend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // payload_byte, payload_length, protocol_number, source_address,
  // destination_address
  input  logic [ihp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // first_byte
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_byte
  output logic [7:0]                    m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ihp_pkg::ADDR_W-1:0]    paddr,
  input  logic [ihp_pkg::DATA_W-1:0]    pwdata,
  output logic [ihp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import ihp_pkg::*;

  logic [7:0] ttl;
  hdr_item_t  in_item;
  logic       pipe_valid;
  logic       pipe_ready;
  hdr_item_t  pipe_item;
  logic [15:0] pipe_csum;
  ser_stat_t  stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= 8'(TTL_RESET);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TTL)) begin
      ttl <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_TTL) ? {24'h000000, ttl} : '0;

  assign in_item.pbyte = s_axis_tdata[7:0];
  assign in_item.first = s_axis_tuser;
  assign in_item.last  = s_axis_tlast;
  assign in_item.plen  = s_axis_tdata[23:8];
  assign in_item.proto = s_axis_tdata[31:24];
  assign in_item.src   = s_axis_tdata[63:32];
  assign in_item.dst   = s_axis_tdata[95:64];
  assign in_item.ttl   = ttl;
  assign in_item.tlen  = 16'h0000;

  ihp_csum u_csum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .ttl       (ttl),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_item  (pipe_item),
    .out_csum  (pipe_csum)
  );

  ihp_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pipe_valid),
    .in_ready  (pipe_ready),
    .in_item   (pipe_item),
    .in_csum   (pipe_csum),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .stat      (stat)
  );

  a_hdr_start: assert property (@(posedge clk) disable iff (rst)
    (pipe_valid && pipe_ready && pipe_item.first) |=>
      (m_axis_tvalid && m_axis_tdata == VER_IHL && !m_axis_tlast))
    else $error("header does not start with version and ihl");

  a_hdr_occupied: assert property (@(posedge clk) disable iff (rst)
    (stat.hdr_left != '0) |-> m_axis_tvalid)
    else $error("header bytes pending with empty output register");

  a_no_last_mid_hdr: assert property (@(posedge clk) disable iff (rst)
    (stat.hdr_left > CNT_W'(1)) |-> !(m_axis_tvalid && m_axis_tlast))
    else $error("tlast raised inside a header");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !stat.busy))
    else $error("output not empty after reset");

endmodule
